>>> rtl/lbs_pkg.sv
// ----------------------------------------------------------------------------
// lbs_pkg
// Shared types and constants of the letterbox bilinear scaler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lbs_pkg;

    localparam int FRAC_BITS    = 8;
    localparam int SCREEN_W     = 800;
    localparam int SCREEN_H     = 480;
    localparam int MAX_SOURCE_W = 256;
    localparam int MAX_SOURCE_H = 256;

    localparam int AX_W   = $clog2(MAX_SOURCE_W);
    localparam int AY_W   = $clog2(MAX_SOURCE_H);
    localparam int ADDR_W = AX_W + AY_W;

    localparam int SW_W = 9;
    localparam int SH_W = 9;
    localparam int BW_W = 10;
    localparam int BH_W = 9;
    localparam int OX_W = 10;
    localparam int OY_W = 9;
    localparam int CH_W = 8;
    localparam int PIX_W = 4 * CH_W;
    localparam int COL_W = 3 * CH_W;

    localparam int NUM_W = BW_W + AX_W + FRAC_BITS;
    localparam int DEN_W = BW_W;
    localparam int WF_W  = FRAC_BITS + 1;
    localparam int WT_W  = 2 * WF_W;
    localparam int ACC_W = 2 * FRAC_BITS + CH_W + 2;

    localparam logic [15:0] RECIP_255 = 16'd32897;
    localparam int          RECIP_SH  = 23;

    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    localparam logic [2:0] REG_SRC_W = 3'd0;
    localparam logic [2:0] REG_SRC_H = 3'd1;
    localparam logic [2:0] REG_BOX_W = 3'd2;
    localparam logic [2:0] REG_BOX_H = 3'd3;
    localparam logic [2:0] REG_ORG_X = 3'd4;
    localparam logic [2:0] REG_ORG_Y = 3'd5;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_RENDER = 1'b1;

    localparam int QDEPTH = 2;

    typedef struct packed {
        logic [SW_W-1:0] src_w;
        logic [SH_W-1:0] src_h;
        logic [BW_W-1:0] box_w;
        logic [BH_W-1:0] box_h;
    } t_cfg;

    typedef struct packed {
        logic             cmd;
        logic             drop;
        logic [AX_W-1:0]  lcol;
        logic [AY_W-1:0]  lrow;
        logic [PIX_W-1:0] rgba;
        logic [BW_W-1:0]  col;
        logic [BH_W-1:0]  row;
        logic [OX_W-1:0]  sx;
        logic [OY_W-1:0]  sy;
    } t_item;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_FIT,
        ST_FIT_DS,
        ST_FIT_DW,
        ST_PLACE,
        ST_CHECK,
        ST_MAP,
        ST_DX_DS,
        ST_DX_DW,
        ST_DY_DS,
        ST_DY_DW,
        ST_COORD,
        ST_ADDR,
        ST_MAC,
        ST_BLEND,
        ST_BMUL,
        ST_BDIV,
        ST_DONE
    } t_state;

endpackage

>>> rtl/lbs_front.sv
// ----------------------------------------------------------------------------
// lbs_front
// Configuration registers and input classification of the scaler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lbs_front import lbs_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_command,
    input  logic [AX_W-1:0]    i_load_col,
    input  logic [AY_W-1:0]    i_load_row,
    input  logic [CH_W-1:0]    i_red_in,
    input  logic [CH_W-1:0]    i_green_in,
    input  logic [CH_W-1:0]    i_blue_in,
    input  logic [CH_W-1:0]    i_alpha_in,
    input  logic [BW_W-1:0]    i_box_col,
    input  logic [BH_W-1:0]    i_box_row,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    input  logic               i_q_full,
    output logic               o_push,
    output t_item              o_item,
    output t_cfg               o_cfg
);

    logic [SW_W-1:0] r_src_w;
    logic [SH_W-1:0] r_src_h;
    logic [BW_W-1:0] r_box_w;
    logic [BH_W-1:0] r_box_h;
    logic [OX_W-1:0] r_org_x;
    logic [OY_W-1:0] r_org_y;
    logic [2:0]      idx;
    logic [OX_W:0]   sx;
    logic [OY_W:0]   sy;

    assign idx    = paddr[PADDR_W-1:2];
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w <= SW_W'(1);
            r_src_h <= SH_W'(1);
            r_box_w <= BW_W'(1);
            r_box_h <= BH_W'(1);
            r_org_x <= '0;
            r_org_y <= '0;
        end else if (psel && penable && pwrite) begin
            case (idx)
                REG_SRC_W: r_src_w <= pwdata[SW_W-1:0];
                REG_SRC_H: r_src_h <= pwdata[SH_W-1:0];
                REG_BOX_W: r_box_w <= pwdata[BW_W-1:0];
                REG_BOX_H: r_box_h <= pwdata[BH_W-1:0];
                REG_ORG_X: r_org_x <= pwdata[OX_W-1:0];
                REG_ORG_Y: r_org_y <= pwdata[OY_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_SRC_W: prdata = PDATA_W'(r_src_w);
            REG_SRC_H: prdata = PDATA_W'(r_src_h);
            REG_BOX_W: prdata = PDATA_W'(r_box_w);
            REG_BOX_H: prdata = PDATA_W'(r_box_h);
            REG_ORG_X: prdata = PDATA_W'(r_org_x);
            REG_ORG_Y: prdata = PDATA_W'(r_org_y);
            default:   prdata = '0;
        endcase
    end

    // clamp source sizes into 1..max
    always_comb begin
        o_cfg.box_w = r_box_w;
        o_cfg.box_h = r_box_h;
        if (r_src_w == '0)
            o_cfg.src_w = SW_W'(1);
        else if (r_src_w > SW_W'(MAX_SOURCE_W))
            o_cfg.src_w = SW_W'(MAX_SOURCE_W);
        else
            o_cfg.src_w = r_src_w;
        if (r_src_h == '0)
            o_cfg.src_h = SH_W'(1);
        else if (r_src_h > SH_W'(MAX_SOURCE_H))
            o_cfg.src_h = SH_W'(MAX_SOURCE_H);
        else
            o_cfg.src_h = r_src_h;
    end

    assign sx = {1'b0, r_org_x} + (OX_W+1)'(i_box_col);
    assign sy = {1'b0, r_org_y} + (OY_W+1)'(i_box_row);

    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full;

    always_comb begin
        o_item.cmd  = i_command;
        o_item.lcol = i_load_col;
        o_item.lrow = i_load_row;
        o_item.rgba = {i_red_in, i_green_in, i_blue_in, i_alpha_in};
        o_item.col  = i_box_col;
        o_item.row  = i_box_row;
        o_item.sx   = sx[OX_W-1:0];
        o_item.sy   = sy[OY_W-1:0];
        o_item.drop = (r_box_w == '0) || (r_box_h == '0) ||
                      (i_box_col >= r_box_w) || (i_box_row >= r_box_h) ||
                      (sx >= (OX_W+1)'(SCREEN_W)) || (sy >= (OY_W+1)'(SCREEN_H));
    end

endmodule

>>> rtl/lbs_fifo.sv
// ----------------------------------------------------------------------------
// lbs_fifo
// Short queue of classified items between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lbs_fifo import lbs_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_item o_item
);

    localparam int PTR_W = $clog2(QDEPTH);

    t_item              r_mem [QDEPTH];
    logic [PTR_W-1:0]   r_wp;
    logic [PTR_W-1:0]   r_rp;
    logic [PTR_W:0]     r_cnt;

    assign o_full  = (r_cnt == (PTR_W+1)'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push)
            r_mem[r_wp] <= i_item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push)
                r_wp <= r_wp + PTR_W'(1);
            if (i_pop)
                r_rp <= r_rp + PTR_W'(1);
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + (PTR_W+1)'(1);
                2'b01:   r_cnt <= r_cnt - (PTR_W+1)'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

>>> rtl/lbs_div.sv
// ----------------------------------------------------------------------------
// lbs_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lbs_div import lbs_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [NUM_W-1:0] r_q;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DEN_W:0]   trial;
    logic             fits;

    assign trial  = {r_rem, r_q[NUM_W-1]};
    assign fits   = trial >= {1'b0, r_den};
    assign o_done = r_done;
    assign o_quot = r_q;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_den <= i_den;
            r_q   <= i_num;
        end else if (r_busy) begin
            r_rem <= fits ? DEN_W'(trial - {1'b0, r_den}) : trial[DEN_W-1:0];
            r_q   <= {r_q[NUM_W-2:0], fits};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

>>> rtl/lbs_back.sv
// ----------------------------------------------------------------------------
// lbs_back
// Image store and sequencer: fit, coordinate mapping, bilinear sum, blend.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lbs_back import lbs_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  logic             i_q_valid,
    input  t_item            i_item,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [OX_W-1:0]  o_screen_x,
    output logic [OY_W-1:0]  o_screen_y,
    output logic [COL_W-1:0] o_pixel_color
);

    localparam logic [WF_W-1:0] ONE = WF_W'(1) << FRAC_BITS;

    logic [PIX_W-1:0] r_mem [2**ADDR_W];

    t_state r_state, n_state;

    t_item                 r_item;
    logic [SW_W+BH_W-1:0]  r_p1;
    logic [BW_W+SH_W-1:0]  r_p2;
    logic [BW_W-1:0]       r_scw;
    logic [BH_W-1:0]       r_sch;
    logic [BW_W-1:0]       r_offx;
    logic [BH_W-1:0]       r_offy;
    logic [BW_W-1:0]       r_i;
    logic [BH_W-1:0]       r_j;
    logic [BW_W+AX_W-1:0]  r_mx;
    logic [BH_W+AY_W-1:0]  r_my;
    logic [NUM_W-1:0]      r_fx;
    logic [NUM_W-1:0]      r_fy;
    logic [AX_W-1:0]       r_x1, r_x2;
    logic [AY_W-1:0]       r_y1, r_y2;
    logic [FRAC_BITS-1:0]  r_dx, r_dy;
    logic [1:0]            r_k, r_c;
    logic [WT_W-1:0]       r_w;
    logic [PIX_W-1:0]      r_pix;
    logic [ACC_W-1:0]      r_acc [4];
    logic [2*CH_W-1:0]     r_bp;
    logic [COL_W-1:0]      r_color;
    logic                  r_ovalid;
    logic [OX_W-1:0]       r_osx;
    logic [OY_W-1:0]       r_osy;
    logic [COL_W-1:0]      r_ocol;

    logic                  wide;
    logic                  div_start, div_done;
    logic [NUM_W-1:0]      div_num, div_quot;
    logic [DEN_W-1:0]      div_den;
    logic                  ofree, in_image, start_render;
    logic [AX_W-1:0]       swm1, x1c, x2c;
    logic [AY_W-1:0]       shm1, y1c, y2c;
    logic [NUM_W-FRAC_BITS-1:0] xi, yi;
    logic [WF_W-1:0]       wa, wb;
    logic [ADDR_W-1:0]     rd_addr;
    logic [CH_W-1:0]       chan, alpha, chv;
    logic [2*CH_W+15:0]    qprod;
    logic [CH_W:0]         qv;
    logic [CH_W-1:0]       qc;

    lbs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign wide  = {1'b0, r_p1} > r_p2;
    assign ofree = !r_ovalid || i_ready;
    assign swm1  = AX_W'(i_cfg.src_w - SW_W'(1));
    assign shm1  = AY_W'(i_cfg.src_h - SH_W'(1));
    assign xi    = r_fx[NUM_W-1:FRAC_BITS];
    assign yi    = r_fy[NUM_W-1:FRAC_BITS];
    assign x1c   = (xi > (NUM_W-FRAC_BITS)'(swm1)) ? swm1 : xi[AX_W-1:0];
    assign y1c   = (yi > (NUM_W-FRAC_BITS)'(shm1)) ? shm1 : yi[AY_W-1:0];
    assign x2c   = (x1c < swm1) ? x1c + AX_W'(1) : x1c;
    assign y2c   = (y1c < shm1) ? y1c + AY_W'(1) : y1c;
    assign wa    = r_k[0] ? WF_W'(r_dx) : ONE - WF_W'(r_dx);
    assign wb    = r_k[1] ? WF_W'(r_dy) : ONE - WF_W'(r_dy);
    assign rd_addr = {(r_k[1] ? r_y2 : r_y1), (r_k[0] ? r_x2 : r_x1)};
    assign chan  = r_pix[{~r_c, 3'b000} +: CH_W];
    assign alpha = r_acc[3][2*FRAC_BITS +: CH_W];
    assign chv   = r_acc[r_c][2*FRAC_BITS +: CH_W];
    assign qprod = r_bp * RECIP_255;
    assign qv    = qprod[RECIP_SH +: CH_W+1];
    assign qc    = (qv > (CH_W+1)'(255)) ? CH_W'(255) : qv[CH_W-1:0];
    assign start_render = i_q_valid && (i_item.cmd == CMD_RENDER) && !i_item.drop;

    assign in_image = (r_item.col >= r_offx) && ((r_item.col - r_offx) < r_scw) &&
                      (r_item.row >= r_offy) && ((r_item.row - r_offy) < r_sch);

    always_comb begin
        case (r_state)
            ST_DX_DS: begin
                div_num = {r_mx, FRAC_BITS'(0)};
                div_den = r_scw - BW_W'(1);
            end
            ST_DY_DS: begin
                div_num = NUM_W'({r_my, FRAC_BITS'(0)});
                div_den = DEN_W'(r_sch - BH_W'(1));
            end
            default: begin
                div_num = wide ? NUM_W'(r_p2) : NUM_W'(r_p1);
                div_den = wide ? DEN_W'(i_cfg.src_w) : DEN_W'(i_cfg.src_h);
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (start_render) n_state = ST_FIT;
            ST_FIT:    n_state = ST_FIT_DS;
            ST_FIT_DS: n_state = ST_FIT_DW;
            ST_FIT_DW: if (div_done) n_state = ST_PLACE;
            ST_PLACE:  n_state = ST_CHECK;
            ST_CHECK:  n_state = in_image ? ST_MAP : ST_DONE;
            ST_MAP:    n_state = ST_DX_DS;
            ST_DX_DS:  n_state = (r_scw > BW_W'(1)) ? ST_DX_DW : ST_DY_DS;
            ST_DX_DW:  if (div_done) n_state = ST_DY_DS;
            ST_DY_DS:  n_state = (r_sch > BH_W'(1)) ? ST_DY_DW : ST_COORD;
            ST_DY_DW:  if (div_done) n_state = ST_COORD;
            ST_COORD:  n_state = ST_ADDR;
            ST_ADDR:   n_state = ST_MAC;
            ST_MAC: begin
                if (r_c == 2'd3)
                    n_state = (r_k == 2'd3) ? ST_BLEND : ST_ADDR;
            end
            ST_BLEND:  n_state = (alpha == '0) ? ST_DONE : ST_BMUL;
            ST_BMUL:   n_state = ST_BDIV;
            ST_BDIV:   n_state = (r_c == 2'd2) ? ST_DONE : ST_BMUL;
            ST_DONE:   if (ofree) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_pop     = 1'b0;
        div_start = 1'b0;
        case (r_state)
            ST_IDLE:   o_pop = i_q_valid;
            ST_FIT_DS: div_start = 1'b1;
            ST_DX_DS:  div_start = r_scw > BW_W'(1);
            ST_DY_DS:  div_start = r_sch > BH_W'(1);
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_state <= ST_IDLE;
        else
            r_state <= n_state;
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_q_valid && i_item.cmd == CMD_LOAD)
            r_mem[{i_item.lrow, i_item.lcol}] <= i_item.rgba;
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_ADDR)
            r_pix <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_item <= i_item;
                r_fx   <= '0;
                r_fy   <= '0;
            end
            ST_FIT: begin
                r_p1 <= i_cfg.src_w * i_cfg.box_h;
                r_p2 <= i_cfg.box_w * i_cfg.src_h;
            end
            ST_FIT_DW: ;
            ST_PLACE: begin
                if (wide) begin
                    r_scw  <= i_cfg.box_w;
                    r_sch  <= div_quot[BH_W-1:0];
                    r_offx <= '0;
                    r_offy <= (i_cfg.box_h - div_quot[BH_W-1:0]) >> 1;
                end else begin
                    r_scw  <= div_quot[BW_W-1:0];
                    r_sch  <= i_cfg.box_h;
                    r_offx <= (i_cfg.box_w - div_quot[BW_W-1:0]) >> 1;
                    r_offy <= '0;
                end
            end
            ST_CHECK: begin
                r_i     <= r_item.col - r_offx;
                r_j     <= r_item.row - r_offy;
                r_color <= '0;
            end
            ST_MAP: begin
                r_mx <= r_i * swm1;
                r_my <= r_j * shm1;
            end
            ST_DX_DW: if (div_done) r_fx <= div_quot;
            ST_DY_DW: if (div_done) r_fy <= div_quot;
            ST_COORD: begin
                r_x1 <= x1c;
                r_x2 <= x2c;
                r_y1 <= y1c;
                r_y2 <= y2c;
                r_dx <= r_fx[FRAC_BITS-1:0];
                r_dy <= r_fy[FRAC_BITS-1:0];
                r_k  <= '0;
                r_c  <= '0;
                for (int n = 0; n < 4; n++)
                    r_acc[n] <= '0;
            end
            ST_ADDR: begin
                r_w <= wa * wb;
                r_c <= '0;
            end
            ST_MAC: begin
                r_acc[r_c] <= r_acc[r_c] + ACC_W'(r_w) * ACC_W'(chan);
                r_c <= r_c + 2'd1;
                if (r_c == 2'd3)
                    r_k <= r_k + 2'd1;
            end
            ST_BLEND: begin
                r_c <= '0;
            end
            ST_BMUL: r_bp <= chv * alpha;
            ST_BDIV: begin
                case (r_c)
                    2'd0:    r_color[2*CH_W +: CH_W] <= qc;
                    2'd1:    r_color[CH_W +: CH_W]   <= qc;
                    default: r_color[0 +: CH_W]      <= qc;
                endcase
                r_c <= r_c + 2'd1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == ST_DONE && ofree) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && ofree) begin
            r_osx  <= r_item.sx;
            r_osy  <= r_item.sy;
            r_ocol <= r_color;
        end
    end

    assign o_valid       = r_ovalid;
    assign o_screen_x    = r_osx;
    assign o_screen_y    = r_osy;
    assign o_pixel_color = r_ocol;

endmodule

>>> rtl/letterbox_bilinear_scaler_core.sv
// ----------------------------------------------------------------------------
// letterbox_bilinear_scaler_core
// Load beats: one a cycle while the back end is idle, no result. Dropped
// renders: no result. Render: a fit pass of the one-bit-per-cycle divider,
// then, inside the image, column and row map passes where that scaled size
// exceeds one, fetch and accumulate of four corners and a blend if alpha > 0.
// A stalled result holds the back end; the queue then fills and drops ready.
// Synchronous active-low reset clears control; the image store is not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module letterbox_bilinear_scaler_core import lbs_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_command,
    input  logic [AX_W-1:0]    i_load_col,
    input  logic [AY_W-1:0]    i_load_row,
    input  logic [CH_W-1:0]    i_red_in,
    input  logic [CH_W-1:0]    i_green_in,
    input  logic [CH_W-1:0]    i_blue_in,
    input  logic [CH_W-1:0]    i_alpha_in,
    input  logic [BW_W-1:0]    i_box_col,
    input  logic [BH_W-1:0]    i_box_row,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [OX_W-1:0]    o_screen_x,
    output logic [OY_W-1:0]    o_screen_y,
    output logic [COL_W-1:0]   o_pixel_color,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    t_cfg  cfg;
    t_item push_item, pop_item;
    logic  q_full, q_push, q_pop, q_valid;

    lbs_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_command  (i_command),
        .i_load_col (i_load_col),
        .i_load_row (i_load_row),
        .i_red_in   (i_red_in),
        .i_green_in (i_green_in),
        .i_blue_in  (i_blue_in),
        .i_alpha_in (i_alpha_in),
        .i_box_col  (i_box_col),
        .i_box_row  (i_box_row),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_item     (push_item),
        .o_cfg      (cfg)
    );

    lbs_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (push_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (pop_item)
    );

    lbs_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_q_valid     (q_valid),
        .i_item        (pop_item),
        .o_pop         (q_pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_screen_x    (o_screen_x),
        .o_screen_y    (o_screen_y),
        .o_pixel_color (o_pixel_color)
    );

endmodule
